### hw/rtl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

   // Port field widths.
   localparam int CFG_W      = 5;
   localparam int PAGE_W     = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int TOTAL_W    = 32;

   // Defaults for the top-level parameters.
   localparam int FRAME_COUNT_DEF = 16;
   localparam int PAGE_BITS_DEF   = 16;

   // Frame count after reset.
   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

endpackage

### hw/rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// Each request makes a search pass and an update pass over the frame memory, one entry
// per cycle through its single read port, then waits in ST_DONE until the response can be
// placed; a new request is accepted only once the last one has left ST_DONE.
// Reset (synchronous, active high) empties every frame, zeroes both totals and sets
// the frame count to 16. A configuration write does the same with the written count.

module lru_page_replacement #(
   parameter int FRAME_COUNT = lpr_pkg::FRAME_COUNT_DEF,
   parameter int PAGE_BITS   = lpr_pkg::PAGE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lpr_pkg::PAGE_W-1:0]     req_page_number,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_was_hit,
   output logic [lpr_pkg::SLOT_OUT_W-1:0] rsp_frame_slot,
   output logic                           rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_W-1:0]     rsp_evicted_page,
   output logic [lpr_pkg::TOTAL_W-1:0]    rsp_hit_total,
   output logic [lpr_pkg::TOTAL_W-1:0]    rsp_fault_total,
   input  logic                           csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0]      csr_wr_data
);
   import lpr_pkg::*;

   localparam int SLOT_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int RANK_W = SLOT_W;
   localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int WORD_W = PAGE_BITS + RANK_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // Each word holds a frame's page and its recency rank (0 is most recent).
   logic [WORD_W-1:0] frame_mem [FRAME_COUNT];
   logic [WORD_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     frames_ff, frames_in;
   logic [FRAME_COUNT-1:0] valid_ff, valid_in;
   logic [TOTAL_W-1:0]   hits_ff, hits_in;
   logic [TOTAL_W-1:0]   faults_ff, faults_in;
   logic                 iss_on_ff, iss_on_in;
   logic [SLOT_W-1:0]    iss_idx_ff, iss_idx_in;
   logic                 dat_vld_ff, dat_vld_in;
   logic [SLOT_W-1:0]    dat_idx_ff, dat_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [SLOT_W-1:0]    last_ff, last_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 hit_ff, hit_in;
   logic [SLOT_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]    hit_rank_ff, hit_rank_in;
   logic                 empty_ff, empty_in;
   logic [SLOT_W-1:0]    empty_idx_ff, empty_idx_in;
   logic [SLOT_W-1:0]    best_idx_ff, best_idx_in;
   logic [RANK_W-1:0]    best_rank_ff, best_rank_in;
   logic [PAGE_BITS-1:0] best_page_ff, best_page_in;

   logic                      was_hit_ff, was_hit_in;
   logic [SLOT_OUT_W-1:0]     slot_out_ff, slot_out_in;
   logic                      evicted_ff, evicted_in;
   logic [PAGE_W-1:0]         evicted_page_ff, evicted_page_in;
   logic [TOTAL_W-1:0]        hit_total_ff, hit_total_in;
   logic [TOTAL_W-1:0]        fault_total_ff, fault_total_in;

   logic [CMP_W-1:0]     cfg_ext;
   logic [SLOT_W-1:0]    act_last;
   logic [PAGE_BITS-1:0] dat_page;
   logic [RANK_W-1:0]    dat_rank;
   logic                 dat_valid;
   logic [SLOT_W-1:0]    sel_idx;
   logic [RANK_W-1:0]    aged_rank;

   // Frame memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= frame_mem[mem_raddr];
   end

   always_comb begin
      cfg_ext = CMP_W'(frames_ff);
      if (cfg_ext == '0) begin
         act_last = '0;
      end else if (cfg_ext > CMP_W'(FRAME_COUNT)) begin
         act_last = SLOT_W'(FRAME_COUNT - 1);
      end else begin
         act_last = SLOT_W'(cfg_ext - 1'b1);
      end
   end

   assign dat_page  = mem_rd_ff[WORD_W-1:RANK_W];
   assign dat_rank  = mem_rd_ff[RANK_W-1:0];
   assign dat_valid = valid_ff[dat_idx_ff];
   assign sel_idx   = hit_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : best_idx_ff);

   // On a hit only frames more recent than the hit frame age; on a fault all of them do.
   assign aged_rank = (!hit_ff || (dat_rank < hit_rank_ff)) ? RANK_W'(dat_rank + 1'b1)
                                                            : dat_rank;

   always_comb begin
      state_in        = state_ff;
      frames_in       = frames_ff;
      valid_in        = valid_ff;
      hits_in         = hits_ff;
      faults_in       = faults_ff;
      iss_on_in       = iss_on_ff;
      iss_idx_in      = iss_idx_ff;
      dat_vld_in      = 1'b0;
      dat_idx_in      = iss_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      last_in         = last_ff;
      page_in         = page_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_rank_in     = hit_rank_ff;
      empty_in        = empty_ff;
      empty_idx_in    = empty_idx_ff;
      best_idx_in     = best_idx_ff;
      best_rank_in    = best_rank_ff;
      best_page_in    = best_page_ff;
      was_hit_in      = was_hit_ff;
      slot_out_in     = slot_out_ff;
      evicted_in      = evicted_ff;
      evicted_page_in = evicted_page_ff;
      hit_total_in    = hit_total_ff;
      fault_total_in  = fault_total_ff;
      mem_we          = 1'b0;
      mem_waddr       = dat_idx_ff;
      mem_wdata       = '0;
      mem_raddr       = iss_idx_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Read issue shared by both passes; the data comes back in the next cycle.
      if (iss_on_ff) begin
         dat_vld_in = 1'b1;
         if (iss_idx_ff == last_ff) begin
            iss_on_in = 1'b0;
         end else begin
            iss_idx_in = SLOT_W'(iss_idx_ff + 1'b1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in    = PAGE_BITS'(req_page_number);
               last_in    = act_last;
               iss_on_in  = 1'b1;
               iss_idx_in = '0;
               hit_in     = 1'b0;
               empty_in   = 1'b0;
               state_in   = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (dat_vld_ff) begin
               if (dat_valid && (dat_page == page_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = dat_idx_ff;
                  hit_rank_in = dat_rank;
               end
               if (!dat_valid && !empty_ff) begin
                  empty_in     = 1'b1;
                  empty_idx_in = dat_idx_ff;
               end
               // Strict compare keeps the lowest frame among equal ranks.
               if ((dat_idx_ff == '0) || (dat_rank > best_rank_ff)) begin
                  best_idx_in  = dat_idx_ff;
                  best_rank_in = dat_rank;
                  best_page_in = dat_page;
               end
               if (dat_idx_ff == last_ff) begin
                  iss_on_in  = 1'b1;
                  iss_idx_in = '0;
                  state_in   = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (dat_vld_ff) begin
               if (dat_idx_ff == sel_idx) begin
                  mem_we               = 1'b1;
                  mem_wdata            = {page_ff, RANK_W'(0)};
                  valid_in[dat_idx_ff] = 1'b1;
               end else if (dat_valid) begin
                  mem_we    = 1'b1;
                  mem_wdata = {dat_page, aged_rank};
               end
               if (dat_idx_ff == last_ff) begin
                  if (hit_ff) begin
                     if (hits_ff != '1) begin
                        hits_in = hits_ff + 1'b1;
                     end
                  end else if (faults_ff != '1) begin
                     faults_in = faults_ff + 1'b1;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               was_hit_in      = hit_ff;
               slot_out_in     = SLOT_OUT_W'(sel_idx);
               evicted_in      = !hit_ff && !empty_ff;
               evicted_page_in = (!hit_ff && !empty_ff) ? PAGE_W'(best_page_ff) : '0;
               hit_total_in    = hits_ff;
               fault_total_in  = faults_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         frames_in = csr_wr_data;
         valid_in  = '0;
         hits_in   = '0;
         faults_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= FRAMES_RESET;
         valid_ff     <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         iss_on_ff    <= 1'b0;
         iss_idx_ff   <= '0;
         dat_vld_ff   <= 1'b0;
         dat_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         valid_ff     <= valid_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         iss_on_ff    <= iss_on_in;
         iss_idx_ff   <= iss_idx_in;
         dat_vld_ff   <= dat_vld_in;
         dat_idx_ff   <= dat_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff         <= last_in;
      page_ff         <= page_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      hit_rank_ff     <= hit_rank_in;
      empty_ff        <= empty_in;
      empty_idx_ff    <= empty_idx_in;
      best_idx_ff     <= best_idx_in;
      best_rank_ff    <= best_rank_in;
      best_page_ff    <= best_page_in;
      was_hit_ff      <= was_hit_in;
      slot_out_ff     <= slot_out_in;
      evicted_ff      <= evicted_in;
      evicted_page_ff <= evicted_page_in;
      hit_total_ff    <= hit_total_in;
      fault_total_ff  <= fault_total_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_hit       = was_hit_ff;
   assign rsp_frame_slot    = slot_out_ff;
   assign rsp_evicted_valid = evicted_ff;
   assign rsp_evicted_page  = evicted_page_ff;
   assign rsp_hit_total     = hit_total_ff;
   assign rsp_fault_total   = fault_total_ff;

endmodule

### hw/rtl/lpr_checker.sv
`timescale 1ns / 1ps

module lpr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_was_hit,
   input logic [lpr_pkg::SLOT_OUT_W-1:0] rsp_frame_slot,
   input logic                           rsp_evicted_valid,
   input logic [lpr_pkg::PAGE_W-1:0]     rsp_evicted_page,
   input logic [lpr_pkg::TOTAL_W-1:0]    rsp_hit_total,
   input logic [lpr_pkg::TOTAL_W-1:0]    rsp_fault_total
);
   import lpr_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_slot)
         && $stable(rsp_was_hit) && $stable(rsp_evicted_page)
         && $stable(rsp_hit_total) && $stable(rsp_fault_total))
      else $error("response changed while stalled");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_hit |-> !rsp_evicted_valid && (rsp_hit_total != '0))
      else $error("hit response reports an eviction or a zero hit total");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_hit |-> (rsp_fault_total != '0))
      else $error("fault response with a zero fault total");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without an eviction");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

### sim/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;

   localparam int FRAMES      = lpr_pkg::FRAME_COUNT_DEF;
   localparam int PAGE_W      = lpr_pkg::PAGE_W;
   localparam int TOTAL_W     = lpr_pkg::TOTAL_W;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 2 * FRAMES + 3 + 10;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 26;

   typedef struct {
      logic                          was_hit;
      logic [lpr_pkg::SLOT_OUT_W-1:0] frame_slot;
      logic                          evicted_valid;
      logic [PAGE_W-1:0]             evicted_page;
      logic [TOTAL_W-1:0]            hit_total;
      logic [TOTAL_W-1:0]            fault_total;
   } frame_result_type;

   class lru_frame_predictor_type;
      logic [PAGE_W-1:0]  page_of[FRAMES];
      bit                 used[FRAMES];
      int unsigned        rank[FRAMES];
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] faults;
      int unsigned        active;
      frame_result_type   expected_q[$];
      int unsigned        errors;

      function void clear(logic [lpr_pkg::CFG_W-1:0] count);
         if (count == 0) active = 1;
         else if (count > FRAMES) active = FRAMES;
         else active = 32'(count);
         for (int j = 0; j < FRAMES; j++) begin
            used[j] = 1'b0;
            rank[j] = 0;
         end
         hits   = '0;
         faults = '0;
      endfunction

      // Every resident frame more recent than the limit gets one step older.
      function void age_frames(int unsigned limit);
         for (int j = 0; j < active; j++) begin
            if (used[j] && rank[j] < limit) rank[j]++;
         end
      endfunction

      function void note_request(logic [PAGE_W-1:0] page);
         frame_result_type r;
         int               slot;
         bit               found;
         r     = '{default: '0};
         slot  = 0;
         found = 1'b0;
         for (int j = 0; j < active; j++) begin
            if (!found && used[j] && page_of[j] == page) begin
               found = 1'b1;
               slot  = j;
            end
         end
         if (found) begin
            age_frames(rank[slot]);
            rank[slot] = 0;
            r.was_hit  = 1'b1;
            if (hits != '1) hits++;
         end else begin
            for (int j = 0; j < active; j++) begin
               if (!found && !used[j]) begin
                  found = 1'b1;
                  slot  = j;
               end
            end
            if (!found) begin
               // The oldest rank loses; ties go to the lowest frame.
               for (int j = 1; j < active; j++) begin
                  if (rank[j] > rank[slot]) slot = j;
               end
               r.evicted_valid = 1'b1;
               r.evicted_page  = page_of[slot];
            end
            age_frames(256);
            rank[slot]    = 0;
            used[slot]    = 1'b1;
            page_of[slot] = page;
            if (faults != '1) faults++;
         end
         r.frame_slot  = lpr_pkg::SLOT_OUT_W'(slot);
         r.hit_total   = hits;
         r.fault_total = faults;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(frame_result_type got);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual slot %0h hit %0b",
                     $time, got.frame_slot, got.was_hit);
            errors++;
         end else begin
            want = expected_q.pop_front();
            compare_field("was_hit", TOTAL_W'(want.was_hit), TOTAL_W'(got.was_hit));
            compare_field("frame_slot", TOTAL_W'(want.frame_slot),
                          TOTAL_W'(got.frame_slot));
            compare_field("evicted_valid", TOTAL_W'(want.evicted_valid),
                          TOTAL_W'(got.evicted_valid));
            compare_field("evicted_page", TOTAL_W'(want.evicted_page),
                          TOTAL_W'(got.evicted_page));
            compare_field("hit_total", want.hit_total, got.hit_total);
            compare_field("fault_total", want.fault_total, got.fault_total);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [PAGE_W-1:0]              req_page_number = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_was_hit;
   logic [lpr_pkg::SLOT_OUT_W-1:0] rsp_frame_slot;
   logic                           rsp_evicted_valid;
   logic [PAGE_W-1:0]              rsp_evicted_page;
   logic [TOTAL_W-1:0]             rsp_hit_total;
   logic [TOTAL_W-1:0]             rsp_fault_total;
   logic                           csr_wr_en = 1'b0;
   logic [lpr_pkg::CFG_W-1:0]      csr_wr_data = '0;

   lru_frame_predictor_type frame_model;
   int unsigned        cycle_count = 0;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_stall_pct = 0;
   int unsigned        hold_requests = 0;
   int unsigned        hold_seen = 0;
   int unsigned        hold_left = 0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_was_hit       (rsp_was_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("lru_page_replacement_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      frame_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) frame_model.note_request(req_page_number);
         if (rsp_valid && rsp_ready) begin
            got.was_hit       = rsp_was_hit;
            got.frame_slot    = rsp_frame_slot;
            got.evicted_valid = rsp_evicted_valid;
            got.evicted_page  = rsp_evicted_page;
            got.hit_total     = rsp_hit_total;
            got.fault_total   = rsp_fault_total;
            frame_model.check_response(got);
         end
      end
   end

   // A long hold-off, once asked for, overrides the random stalls.
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_page(logic [PAGE_W-1:0] page);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_model.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_frames(logic [lpr_pkg::CFG_W-1:0] count);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      frame_model.clear(count);
   endtask

   // Mostly references within a small working set near the frame count, so that
   // hits and evictions both show up, with some pages drawn from the whole range.
   function automatic logic [PAGE_W-1:0] pick_page(logic [PAGE_W-1:0] base,
                                                   int unsigned span);
      if ($urandom_range(99) < 15) return PAGE_W'($urandom_range(65535));
      return base + PAGE_W'($urandom_range(span - 1));
   endfunction

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
      logic [PAGE_W-1:0] base;
      int unsigned       span;
      base           = PAGE_W'($urandom_range(65535));
      span           = $urandom_range(frame_model.active + 4, 1);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) send_page(pick_page(base, span));
   endtask

   initial begin
      logic [lpr_pkg::CFG_W-1:0] count;
      frame_model = new();
      frame_model.errors = 0;
      frame_model.clear(lpr_pkg::FRAMES_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, starting from the frame count that reset leaves.
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hAAAA);
      send_page(16'h5555);

      // A single frame: every fault after the first evicts.
      write_frames(5'd1);
      send_page(16'h1234);
      send_page(16'h1234);
      send_page(16'h4321);
      send_page(16'h1234);

      // A count of zero behaves as one frame.
      write_frames(5'd0);
      send_page(16'h0007);
      send_page(16'h0007);
      send_page(16'h0008);

      write_frames(5'd2);
      send_page(16'h000A);
      send_page(16'h000B);
      send_page(16'h000A);
      send_page(16'h000C);
      send_page(16'h000B);

      write_frames(5'd3);
      send_page(16'h0001);
      send_page(16'h0002);
      send_page(16'h0003);
      send_page(16'h0001);
      send_page(16'h0004);

      // Random part: each setting goes through every idling mix.
      for (int s = 0; s < 8; s++) begin
         case (s)
            0: count = 5'd16;
            1: count = 5'd1;
            2: count = 5'd0;
            3: count = 5'd4;
            4: count = 5'd31;
            5: count = 5'd17;
            6: count = lpr_pkg::CFG_W'($urandom_range(15, 2));
            default: count = lpr_pkg::CFG_W'($urandom_range(31));
         endcase
         write_frames(count);
         if (s == 0) hold_requests++;
         run_phase(0, 0);
         run_phase(83, 0);
         run_phase(0, 83);
         run_phase(26, 26);
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (frame_model.errors == 0 && frame_model.expected_q.size() == 0) begin
         $display("lru_page_replacement_tb: PASS");
      end else begin
         $display("lru_page_replacement_tb: FAIL");
      end
      $finish;
   end

endmodule
